@@ hw/rtl/pei_pkg.sv @@
`timescale 1ns / 1ps

package pei_pkg;

  localparam int unsigned AXES      = 3;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned IMASS_W   = 25;
  localparam int unsigned DT_W      = 17;
  localparam int unsigned PROD_W    = WORD_W + IMASS_W + 1;
  localparam int unsigned SHIFTED_W = PROD_W - FRAC_W;
  localparam int unsigned SUM_W     = SHIFTED_W + 1;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [IMASS_W-1:0] IMASS_RST     = 25'd65536;
  localparam logic [DT_W-1:0]    DT_RST        = 17'd1049;
  localparam logic [WORD_W-1:0]  AGE_LIMIT_RST = 32'd655360;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_MASS  = 2'd0,
    CFG_TIME_STEP = 2'd1,
    CFG_AGE_LIMIT = 2'd2
  } pei_cfg_idx_t;

  typedef enum logic {
    OP_ADD_FORCE = 1'b0,
    OP_TICK      = 1'b1
  } pei_op_t;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_SAT_ACC = 7'b0000010,
    ST_MUL_VEL = 7'b0000100,
    ST_ADD_VEL = 7'b0001000,
    ST_MUL_POS = 7'b0010000,
    ST_ADD_POS = 7'b0100000,
    ST_FINISH  = 7'b1000000
  } pei_state_t;

  typedef struct packed {
    logic add_force;
    logic start;
    logic sat_acc;
    logic mul_vel;
    logic add_vel;
    logic mul_pos;
    logic add_pos;
    logic load_out;
  } pei_cmd_t;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if ((&v[SUM_W-1:WORD_W-1]) || !(|v[SUM_W-1:WORD_W-1])) begin
      r = v[WORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(WORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/pei_ctrl.sv @@
`timescale 1ns / 1ps

module pei_ctrl
  import pei_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output pei_cmd_t cmd
);

  pei_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_TICK) begin
            cmd.start = 1'b1;
            state_nxt = ST_SAT_ACC;
          end else begin
            cmd.add_force = 1'b1;
          end
        end
      end
      ST_SAT_ACC: begin
        cmd.sat_acc = 1'b1;
        state_nxt   = ST_MUL_VEL;
      end
      ST_MUL_VEL: begin
        cmd.mul_vel = 1'b1;
        state_nxt   = ST_ADD_VEL;
      end
      ST_ADD_VEL: begin
        cmd.add_vel = 1'b1;
        state_nxt   = ST_MUL_POS;
      end
      ST_MUL_POS: begin
        cmd.mul_pos = 1'b1;
        state_nxt   = ST_ADD_POS;
      end
      ST_ADD_POS: begin
        cmd.add_pos = 1'b1;
        state_nxt   = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/pei_datapath.sv @@
`timescale 1ns / 1ps

module pei_datapath
  import pei_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  pei_cmd_t                 cmd,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [WORD_W-1:0]        cfg_wdata,
  input  logic signed [WORD_W-1:0] in_force_x,
  input  logic signed [WORD_W-1:0] in_force_y,
  input  logic signed [WORD_W-1:0] in_force_z,
  output logic signed [WORD_W-1:0] out_pos_x,
  output logic signed [WORD_W-1:0] out_pos_y,
  output logic signed [WORD_W-1:0] out_pos_z,
  output logic signed [WORD_W-1:0] out_vel_x,
  output logic signed [WORD_W-1:0] out_vel_y,
  output logic signed [WORD_W-1:0] out_vel_z,
  output logic signed [WORD_W-1:0] out_accel_x,
  output logic signed [WORD_W-1:0] out_accel_y,
  output logic signed [WORD_W-1:0] out_accel_z,
  output logic                     out_expired
);

  logic [IMASS_W-1:0] inv_mass_r;
  logic [DT_W-1:0]    dt_r;
  logic [WORD_W-1:0]  age_limit_r;
  logic [WORD_W-1:0]  age_r;
  logic [WORD_W:0]    age_sum;

  logic signed [WORD_W-1:0]    force_r [AXES];
  logic signed [WORD_W-1:0]    vel_r   [AXES];
  logic signed [WORD_W-1:0]    pos_r   [AXES];
  logic signed [WORD_W-1:0]    acc_r   [AXES];
  logic signed [SHIFTED_W-1:0] prod_r  [AXES];

  logic signed [WORD_W-1:0] in_force [AXES];
  logic signed [WORD_W-1:0] mul_a    [AXES];
  logic signed [PROD_W-1:0] full     [AXES];
  logic signed [SUM_W-1:0]  upd_sum  [AXES];
  logic signed [WORD_W-1:0] force_nxt[AXES];
  logic signed [WORD_W-1:0] upd_sat  [AXES];
  logic signed [WORD_W-1:0] acc_nxt  [AXES];
  logic [IMASS_W-1:0]       mul_b;

  logic signed [WORD_W-1:0] pos_out_r [AXES];
  logic signed [WORD_W-1:0] vel_out_r [AXES];
  logic signed [WORD_W-1:0] acc_out_r [AXES];
  logic                     expired_r;

  assign in_force[0] = in_force_x;
  assign in_force[1] = in_force_y;
  assign in_force[2] = in_force_z;

  assign mul_b   = cmd.start ? inv_mass_r : IMASS_W'(dt_r);
  assign age_sum = {1'b0, age_r} + (WORD_W + 1)'(dt_r);

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      if (cmd.start) begin
        mul_a[i] = force_r[i];
      end else if (cmd.mul_vel) begin
        mul_a[i] = acc_r[i];
      end else begin
        mul_a[i] = vel_r[i];
      end
      full[i]      = PROD_W'(mul_a[i]) * PROD_W'($signed({1'b0, mul_b}));
      upd_sum[i]   = SUM_W'(prod_r[i]) + SUM_W'(cmd.add_vel ? vel_r[i] : pos_r[i]);
      upd_sat[i]   = sat32(upd_sum[i]);
      force_nxt[i] = sat32(SUM_W'(force_r[i]) + SUM_W'(in_force[i]));
      acc_nxt[i]   = sat32(SUM_W'(prod_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_mass_r  <= IMASS_RST;
      dt_r        <= DT_RST;
      age_limit_r <= AGE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INV_MASS:  inv_mass_r  <= cfg_wdata[IMASS_W-1:0];
        CFG_TIME_STEP: dt_r        <= cfg_wdata[DT_W-1:0];
        CFG_AGE_LIMIT: age_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_r <= '0;
      for (int i = 0; i < AXES; i++) begin
        force_r[i] <= '0;
        vel_r[i]   <= '0;
        pos_r[i]   <= '0;
      end
    end else begin
      if (cmd.start) begin
        age_r <= age_sum[WORD_W] ? {WORD_W{1'b1}} : age_sum[WORD_W-1:0];
      end
      for (int i = 0; i < AXES; i++) begin
        if (cmd.add_force) begin
          force_r[i] <= force_nxt[i];
        end else if (cmd.sat_acc) begin
          force_r[i] <= '0;
        end
        if (cmd.add_vel) begin
          vel_r[i] <= upd_sat[i];
        end
        if (cmd.add_pos) begin
          pos_r[i] <= upd_sat[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < AXES; i++) begin
      if (cmd.start || cmd.mul_vel || cmd.mul_pos) begin
        prod_r[i] <= full[i][PROD_W-1:FRAC_W];
      end
      if (cmd.sat_acc) begin
        acc_r[i] <= acc_nxt[i];
      end
      if (cmd.load_out) begin
        pos_out_r[i] <= pos_r[i];
        vel_out_r[i] <= vel_r[i];
        acc_out_r[i] <= acc_r[i];
      end
    end
    if (cmd.load_out) begin
      expired_r <= (age_r > age_limit_r);
    end
  end

  assign out_pos_x   = pos_out_r[0];
  assign out_pos_y   = pos_out_r[1];
  assign out_pos_z   = pos_out_r[2];
  assign out_vel_x   = vel_out_r[0];
  assign out_vel_y   = vel_out_r[1];
  assign out_vel_z   = vel_out_r[2];
  assign out_accel_x = acc_out_r[0];
  assign out_accel_y = acc_out_r[1];
  assign out_accel_z = acc_out_r[2];
  assign out_expired = expired_r;

endmodule

@@ hw/rtl/particle_euler_integrator_core.sv @@
// Semi-implicit Euler integrator for one particle, signed Q16.16 fixed point.
// Input channel (in_valid/in_ready): in_op low adds in_force_x/y/z into a
// saturating force accumulator and gives no result; in_op high runs one step.
// Result channel (out_valid/out_ready): one transfer per step, carrying the
// new position, the new velocity, the acceleration and the expired flag.
// An add-force transfer leaves the block ready again at once.
// A step runs through the states SAT_ACC, MUL_VEL, ADD_VEL, MUL_POS, ADD_POS
// and FINISH before its result appears, and no new step is accepted until
// the block is back in idle: three multiplications per axis run one after
// another on one multiplier per axis, each followed by a saturating update.
// Results sit in an output register; while one waits, the block keeps
// accepting add-force transfers and may start the next step, which then holds
// in its last state until the pending result has been taken.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once and
// are intended to be made only while the block is idle.
// A synchronous reset (rst_n low) clears position, velocity, force and age,
// restores the default configuration and drops any pending result.
`timescale 1ns / 1ps

module particle_euler_integrator_core
  import pei_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [WORD_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_op,
  input  logic signed [WORD_W-1:0] in_force_x,
  input  logic signed [WORD_W-1:0] in_force_y,
  input  logic signed [WORD_W-1:0] in_force_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] out_pos_x,
  output logic signed [WORD_W-1:0] out_pos_y,
  output logic signed [WORD_W-1:0] out_pos_z,
  output logic signed [WORD_W-1:0] out_vel_x,
  output logic signed [WORD_W-1:0] out_vel_y,
  output logic signed [WORD_W-1:0] out_vel_z,
  output logic signed [WORD_W-1:0] out_accel_x,
  output logic signed [WORD_W-1:0] out_accel_y,
  output logic signed [WORD_W-1:0] out_accel_z,
  output logic                     out_expired
);

  pei_cmd_t cmd;

  pei_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  pei_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_force_x  (in_force_x),
    .in_force_y  (in_force_y),
    .in_force_z  (in_force_z),
    .out_pos_x   (out_pos_x),
    .out_pos_y   (out_pos_y),
    .out_pos_z   (out_pos_z),
    .out_vel_x   (out_vel_x),
    .out_vel_y   (out_vel_y),
    .out_vel_z   (out_vel_z),
    .out_accel_x (out_accel_x),
    .out_accel_y (out_accel_y),
    .out_accel_z (out_accel_z),
    .out_expired (out_expired)
  );

endmodule

@@ hw/rtl/pei_checker.sv @@
`timescale 1ns / 1ps

module pei_checker
  import pei_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_op,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [WORD_W-1:0] out_pos_x,
  input logic                     out_expired
);

  // A pending result is held steady until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_expired))
    else $error("pending result changed before its transfer");

  // An add-force transfer never makes the block busy.
  a_force_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_ADD_FORCE) |=> in_ready)
    else $error("block busy after an add-force transfer");

  // A step transfer makes the block busy.
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_TICK) |=> !in_ready)
    else $error("block ready straight after a step transfer");

  // A new result only appears as a step completes.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a step in progress");

  // Reset drops any pending result.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind particle_euler_integrator_core pei_checker u_pei_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_op       (in_op),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_pos_x   (out_pos_x),
  .out_expired (out_expired)
);
